[src/msd_pkg.sv]
// ----------------------------------------------------------------------------
// msd_pkg: shared definitions for the multiplexed seven-segment driver
// Holds the command codes, configuration register indexes, the configuration
// bundle type and the fixed field widths used by the driver modules.
// ----------------------------------------------------------------------------
package msd_pkg;

	// Input item kinds carried on the slave tuser bit.
	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_TICK  = 1'b1
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DISPLAY_ENABLE     = 2'd0,
		REG_SEGMENT_ACTIVE_LOW = 2'd1,
		REG_DIGIT_ACTIVE_LOW   = 2'd2
	} reg_idx_t;

	// Field widths fixed by the item format.
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned SEG_W  = 8;
	localparam int unsigned PIN_W  = 4;

	// Configuration bundle handed from the register bank to the scan core.
	typedef struct packed {
		logic display_enable;
		logic segment_active_low;
		logic digit_active_low;
	} cfg_t;

endpackage

[src/msd_char_enc.sv]
// ----------------------------------------------------------------------------
// msd_char_enc: character to segment pattern encoder
// Maps the 7-bit character through the fixed glyph table and adds the
// decimal point from bit 7. Pure combinational logic.
// ----------------------------------------------------------------------------
module msd_char_enc (
	input  logic [msd_pkg::CHAR_W-1:0] char_code,
	output logic [msd_pkg::SEG_W-1:0]  pattern
);
	import msd_pkg::*;

	// Segments a to g in bits 0 to 6; zero marks a character with no glyph.
	function automatic logic [6:0] glyph(input logic [6:0] ch);
		logic [6:0] g;
		begin
			g = 7'h00;
			case (ch)
				7'h30: g = 7'h3F; // '0'
				7'h31: g = 7'h06;
				7'h32: g = 7'h5B;
				7'h33: g = 7'h4F;
				7'h34: g = 7'h66;
				7'h35: g = 7'h6D;
				7'h36: g = 7'h7D;
				7'h37: g = 7'h07;
				7'h38: g = 7'h7F;
				7'h39: g = 7'h6F; // '9'
				7'h41: g = 7'h77; // 'A'
				7'h43: g = 7'h39; // 'C'
				7'h45: g = 7'h79; // 'E'
				7'h46: g = 7'h71; // 'F'
				7'h47: g = 7'h3D; // 'G'
				7'h48: g = 7'h76; // 'H'
				7'h4A: g = 7'h1E; // 'J'
				7'h4C: g = 7'h38; // 'L'
				7'h4E: g = 7'h37; // 'N'
				7'h50: g = 7'h73; // 'P'
				7'h55: g = 7'h3E; // 'U'
				7'h59: g = 7'h6E; // 'Y'
				7'h61: g = 7'h5F; // 'a'
				7'h62: g = 7'h7C; // 'b'
				7'h63: g = 7'h58; // 'c'
				7'h64: g = 7'h5E; // 'd'
				7'h65: g = 7'h7B; // 'e'
				7'h68: g = 7'h74; // 'h'
				7'h69: g = 7'h10; // 'i'
				7'h6A: g = 7'h0E; // 'j'
				7'h6C: g = 7'h06; // 'l'
				7'h6E: g = 7'h54; // 'n'
				7'h6F: g = 7'h5C; // 'o'
				7'h71: g = 7'h67; // 'q'
				7'h72: g = 7'h50; // 'r'
				7'h74: g = 7'h78; // 't'
				7'h75: g = 7'h1C; // 'u'
				default: g = 7'h00;
			endcase
			return g;
		end
	endfunction

	logic [6:0] seg_a_g;
	logic       is_space;

	// A space shows only the point; an unknown character is fully blank.
	always_comb begin
		seg_a_g  = glyph(char_code[6:0]);
		is_space = (char_code[6:0] == 7'h20);
		if (is_space) begin
			pattern = {char_code[7], 7'h00};
		end else if (seg_a_g == 7'h00) begin
			pattern = '0;
		end else begin
			pattern = {char_code[7], seg_a_g};
		end
	end

endmodule

[src/msd_scan_core.sv]
// ----------------------------------------------------------------------------
// msd_scan_core: digit pattern store and scan sequencer
// Holds one segment pattern per digit and the scan position, and forms the
// segment and digit pins of a tick at the configured polarity.
// ----------------------------------------------------------------------------
module msd_scan_core #(
	parameter int DIGITS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  msd_pkg::cfg_t              cfg,
	input  logic                       commit,
	input  msd_pkg::cmd_t              command,
	input  logic [msd_pkg::IDX_W-1:0]  digit_index,
	input  logic [msd_pkg::SEG_W-1:0]  pattern,
	output logic [msd_pkg::SEG_W-1:0]  segment_pins,
	output logic [msd_pkg::PIN_W-1:0]  digit_pins
);
	import msd_pkg::*;

	localparam int POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

	logic [SEG_W-1:0]  patterns_q [DIGITS];
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pos_next;
	logic [DIGITS-1:0] dig_sel;
	logic [SEG_W-1:0]  seg_raw;
	logic              is_tick;

	assign is_tick  = (command == CMD_TICK);
	assign pos_next = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);

	// Pattern store: a write fills its slot when the slot exists.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGITS; i++) begin
				patterns_q[i] <= '0;
			end
		end else if (commit && !is_tick) begin
			for (int i = 0; i < DIGITS; i++) begin
				if (int'(digit_index) == i) begin
					patterns_q[i] <= pattern;
				end
			end
		end
	end

	// Scan position advances on an enabled tick and wraps at the digit count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (commit && is_tick && cfg.display_enable) begin
			pos_q <= pos_next;
		end
	end

	// Pin formation with polarity; pins past the digit count stay low.
	always_comb begin
		if (cfg.display_enable) begin
			seg_raw = patterns_q[pos_q];
			dig_sel = DIGITS'(1) << pos_q;
		end else begin
			seg_raw = '0;
			dig_sel = '0;
		end
		segment_pins = cfg.segment_active_low ? ~seg_raw : seg_raw;
		if (cfg.digit_active_low) begin
			dig_sel = ~dig_sel;
		end
		digit_pins = '0;
		for (int i = 0; i < PIN_W; i++) begin
			if (i < DIGITS) begin
				digit_pins[i] = dig_sel[i];
			end
		end
	end

	// The scan position never reaches the digit count.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < DIGITS)
		else $error("scan position out of range");

	// An enabled tick moves the position to the following digit.
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_tick && cfg.display_enable) |=> (pos_q == $past(pos_next)))
		else $error("scan position did not advance");

	// A disabled tick or a write leaves the position in place.
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !(is_tick && cfg.display_enable)) |=> $stable(pos_q))
		else $error("scan position moved without an enabled tick");

endmodule

[src/multiplexed_seven_segment_driver_unit.sv]
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_unit: multiplexed seven-segment driver
// Stream-fed display scanner: write transactions load digit glyphs, tick
// transactions produce one set of segment and digit pin values each.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while no tick is stalled.
// An accepted transaction is held in an input register, where the glyph
// lookup and the scan logic run, and a tick then lands in the output register,
// from which its result is offered on the master side. Write transactions
// return nothing. The input side keeps accepting while a result waits on the
// master side, except when a tick sits in the input register behind a result
// that has not yet been taken.
module multiplexed_seven_segment_driver_unit #(
	parameter int DIGITS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream: tdata from bit 0 up = digit_index[1:0], char_code[7:0], pad[5:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	// Slave stream: tuser = command
	input  logic        s_axis_tuser,
	// Master stream: tdata from bit 0 up = segment_pins[7:0], digit_pins[3:0], pad[3:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic        cfg_wdata
);
	import msd_pkg::*;

	cfg_t                cfg_q;
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [CHAR_W-1:0]   char_s1;
	logic                out_valid_q;
	logic [SEG_W-1:0]    seg_q;
	logic [PIN_W-1:0]    dig_q;
	logic                out_free;
	logic                s1_go;
	logic                in_fire;
	logic [SEG_W-1:0]    pattern;
	logic [SEG_W-1:0]    seg_pins;
	logic [PIN_W-1:0]    dig_pins;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_DISPLAY_ENABLE:     cfg_q.display_enable     <= cfg_wdata;
				REG_SEGMENT_ACTIVE_LOW: cfg_q.segment_active_low <= cfg_wdata;
				REG_DIGIT_ACTIVE_LOW:   cfg_q.digit_active_low   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: a write always leaves stage 1, a tick needs a free output slot.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_go         = valid_s1 && ((cmd_s1 == CMD_WRITE) || out_free);
	assign s_axis_tready = !valid_s1 || s1_go;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			idx_s1  <= s_axis_tdata[IDX_W-1:0];
			char_s1 <= s_axis_tdata[IDX_W+CHAR_W-1:IDX_W];
		end
	end

	// Glyph lookup for write transactions.
	msd_char_enc u_enc (
		.char_code (char_s1),
		.pattern   (pattern)
	);

	// Pattern store, scan position and pin formation.
	msd_scan_core #(
		.DIGITS (DIGITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.commit       (s1_go),
		.command      (cmd_s1),
		.digit_index  (idx_s1),
		.pattern      (pattern),
		.segment_pins (seg_pins),
		.digit_pins   (dig_pins)
	);

	// Output register: loaded by a tick, emptied when the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && (cmd_s1 == CMD_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (cmd_s1 == CMD_TICK)) begin
			seg_q <= seg_pins;
			dig_q <= dig_pins;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, dig_q, seg_q};

	// A tick is never moved into an occupied output slot that is not drained.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (cmd_s1 == CMD_TICK)) |-> out_free)
		else $error("result overwritten before transfer");

	// A tick stalled in stage 1 keeps the input side closed.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cmd_s1 == CMD_TICK) && !out_free) |-> !s_axis_tready)
		else $error("input accepted while stage 1 is stalled");

	// A write in stage 1 never raises a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cmd_s1 == CMD_WRITE) && !out_valid_q) |=> !m_axis_tvalid)
		else $error("write transaction produced a result");

endmodule

[tb/tb_multiplexed_seven_segment_driver_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_driver_unit: display scanner testbench
// Drives write and tick transactions into the driver and checks each tick
// result against a typed value or an in-bench model of the glyph store and
// scan position. A short directed table leads, then phases of random traffic
// under every polarity and enable setting, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_multiplexed_seven_segment_driver_unit;
	import msd_pkg::*;

	localparam int NUM_DIGITS = 4;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 200;
	// Index past the last register; writes to it must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// One line of the directed table.
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  addr;
		logic        wval;
		cmd_t        cmd;
		logic [1:0]  idx;
		logic [7:0]  code;
		bit          typed;
		logic [7:0]  seg;
		logic [3:0]  dig;
	} step_row_t;

	// Per-transaction note: a typed expectation replaces the predicted one.
	typedef struct {
		bit          typed;
		logic [7:0]  seg;
		logic [3:0]  dig;
	} typed_pins_t;

	typedef struct {
		logic [7:0]  seg;
		logic [3:0]  dig;
	} pin_values_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic        cfg_wdata = 1'b0;

	// Model state of the display.
	logic [7:0]  pattern_ram [NUM_DIGITS];
	int unsigned scan_pos;
	cfg_t        disp_cfg;

	pin_values_t pin_expect_q [$];
	typed_pins_t typed_pin_q [$];
	step_row_t   directed_rows [$];

	int          err_count = 0;
	int          cycle_count = 0;
	bit          src_burst = 1'b0;
	bit          sink_steady = 1'b0;
	bit          long_hold_req = 1'b0;
	string       glyph_chars = "0123456789ACEFGHJLNPUYabcdehijlnoqrtu";

	multiplexed_seven_segment_driver_unit #(
		.DIGITS(NUM_DIGITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Fixed glyph table on the low seven bits of a character.
	function automatic logic [6:0] glyph_lookup(input logic [6:0] ch);
		case (ch)
			"0": return 7'h3F;
			"1": return 7'h06;
			"2": return 7'h5B;
			"3": return 7'h4F;
			"4": return 7'h66;
			"5": return 7'h6D;
			"6": return 7'h7D;
			"7": return 7'h07;
			"8": return 7'h7F;
			"9": return 7'h6F;
			"A": return 7'h77;
			"C": return 7'h39;
			"E": return 7'h79;
			"F": return 7'h71;
			"G": return 7'h3D;
			"H": return 7'h76;
			"J": return 7'h1E;
			"L": return 7'h38;
			"N": return 7'h37;
			"P": return 7'h73;
			"U": return 7'h3E;
			"Y": return 7'h6E;
			"a": return 7'h5F;
			"b": return 7'h7C;
			"c": return 7'h58;
			"d": return 7'h5E;
			"e": return 7'h7B;
			"h": return 7'h74;
			"i": return 7'h10;
			"j": return 7'h0E;
			"l": return 7'h06;
			"n": return 7'h54;
			"o": return 7'h5C;
			"q": return 7'h67;
			"r": return 7'h50;
			"t": return 7'h78;
			"u": return 7'h1C;
			default: return 7'h00;
		endcase
	endfunction

	// A space keeps only the point; an unknown character is blank, point or not.
	function automatic logic [7:0] encode_glyph(input logic [7:0] code);
		logic [6:0] g;
		g = glyph_lookup(code[6:0]);
		if (code[6:0] == 7'h20)
			return {code[7], 7'h00};
		if (g == 7'h00)
			return 8'h00;
		return {code[7], g};
	endfunction

	// Applies one accepted transaction to the model; returns 1 for a tick.
	function automatic bit predict_pins(input cmd_t cmd, input logic [1:0] idx,
		input logic [7:0] code, output pin_values_t pins);
		logic [7:0] seg;
		logic [3:0] dig;
		logic [3:0] mask;
		seg = 8'h00;
		dig = 4'h0;
		mask = 4'((1 << NUM_DIGITS) - 1);
		pins = '{seg: 8'h00, dig: 4'h0};
		if (cmd == CMD_WRITE) begin
			if (int'(idx) < NUM_DIGITS)
				pattern_ram[idx] = encode_glyph(code);
			return 1'b0;
		end
		if (disp_cfg.display_enable) begin
			seg = pattern_ram[scan_pos];
			dig = 4'(1 << scan_pos);
			scan_pos = (scan_pos + 1) % NUM_DIGITS;
		end
		if (disp_cfg.segment_active_low)
			seg = ~seg;
		if (disp_cfg.digit_active_low)
			dig = dig ^ mask;
		pins.seg = seg;
		pins.dig = dig & mask;
		return 1'b1;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Monitor: checks results and feeds accepted transactions to the model.
	always @(posedge clk) begin
		pin_values_t got;
		pin_values_t want;
		typed_pins_t note;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.seg = m_axis_tdata[7:0];
				got.dig = m_axis_tdata[11:8];
				if (pin_expect_q.size() == 0) begin
					$display("%0t: unexpected result seg=%h dig=%h", $time,
						got.seg, got.dig);
					err_count++;
				end else begin
					want = pin_expect_q.pop_front();
					if (got.seg !== want.seg) begin
						$display("%0t: segment_pins expected %h actual %h", $time,
							want.seg, got.seg);
						err_count++;
					end
					if (got.dig !== want.dig) begin
						$display("%0t: digit_pins expected %h actual %h", $time,
							want.dig, got.dig);
						err_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				note = typed_pin_q.pop_front();
				if (predict_pins(cmd_t'(s_axis_tuser), s_axis_tdata[1:0],
					s_axis_tdata[9:2], want)) begin
					if (note.typed) begin
						want.seg = note.seg;
						want.dig = note.dig;
					end
					pin_expect_q.push_back(want);
				end
			end
		end
	end

	// Receiver: random stalls, steady stretches and one long hold-off.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (sink_steady || $urandom_range(0, 99) < 65) begin
				m_axis_tready <= 1'b1;
			end else begin
				hold_left = pick_gap();
				m_axis_tready <= 1'b0;
			end
		end
	end

	// Run time limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_multiplexed_seven_segment_driver_unit failed");
		$finish;
	end

	// Offers one transaction and returns at the edge where it is accepted.
	task automatic send_item(input cmd_t cmd, input logic [1:0] idx,
		input logic [7:0] code, input typed_pins_t note);
		int gap;
		gap = src_burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_pin_q.push_back(note);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'b0, code, idx};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops offering and waits until every result is in and the pipe is empty.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pin_expect_q.size() != 0 || typed_pin_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the model follows once the block has sampled it.
	task automatic write_reg(input logic [1:0] addr, input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (addr)
			REG_DISPLAY_ENABLE:     disp_cfg.display_enable = val;
			REG_SEGMENT_ACTIVE_LOW: disp_cfg.segment_active_low = val;
			REG_DIGIT_ACTIVE_LOW:   disp_cfg.digit_active_low = val;
			default: ;
		endcase
	endtask

	function automatic void cfg_row(input logic [1:0] addr, input logic val);
		step_row_t row;
		row = '{kind: ROW_CFG, addr: addr, wval: val, cmd: CMD_WRITE, idx: 2'd0,
			code: 8'h00, typed: 1'b0, seg: 8'h00, dig: 4'h0};
		directed_rows.push_back(row);
	endfunction

	function automatic void item_row(input cmd_t cmd, input logic [1:0] idx,
		input logic [7:0] code, input bit typed, input logic [7:0] seg,
		input logic [3:0] dig);
		step_row_t row;
		row = '{kind: ROW_ITEM, addr: 2'd0, wval: 1'b0, cmd: cmd, idx: idx,
			code: code, typed: typed, seg: seg, dig: dig};
		directed_rows.push_back(row);
	endfunction

	// Random transaction, mostly well-formed characters and scan ticks.
	task automatic send_random();
		typed_pins_t note;
		logic [7:0]  code;
		int          r;
		note = '{typed: 1'b0, seg: 8'h00, dig: 4'h0};
		if ($urandom_range(0, 99) < 45) begin
			send_item(CMD_TICK, 2'($urandom_range(0, 3)), 8'($urandom), note);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60)
				code = {1'($urandom), 7'(glyph_chars[$urandom_range(0,
					glyph_chars.len() - 1)])};
			else if (r < 75)
				code = {1'($urandom), 7'h20};
			else
				code = 8'($urandom);
			send_item(CMD_WRITE, 2'($urandom_range(0, 3)), code, note);
		end
	endtask

	// Stimulus.
	initial begin
		step_row_t   row;
		typed_pins_t note;
		logic [2:0]  phase_cfg;

		foreach (pattern_ram[i])
			pattern_ram[i] = 8'h00;
		scan_pos = 0;
		disp_cfg = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Blanking and polarity after reset, then the encoding special cases.
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h0);
		cfg_row(REG_SEGMENT_ACTIVE_LOW, 1'b1);
		item_row(CMD_TICK, 2'd3, 8'hFF, 1'b1, 8'hFF, 4'h0);
		cfg_row(REG_DIGIT_ACTIVE_LOW, 1'b1);
		item_row(CMD_TICK, 2'd1, 8'h55, 1'b1, 8'hFF, 4'hF);
		cfg_row(REG_SPARE, 1'b1);
		cfg_row(REG_SEGMENT_ACTIVE_LOW, 1'b0);
		cfg_row(REG_DIGIT_ACTIVE_LOW, 1'b0);
		cfg_row(REG_DISPLAY_ENABLE, 1'b1);
		item_row(CMD_WRITE, 2'd0, 8'hB0, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd1, 8'hA0, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd2, 8'h20, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd3, 8'hFF, 1'b0, 8'h00, 4'h0);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'hBF, 4'h1);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h80, 4'h2);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h4);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h8);
		item_row(CMD_WRITE, 2'd0, 8'h00, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd1, 8'h41, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd2, 8'hF7, 1'b0, 8'h00, 4'h0);
		item_row(CMD_WRITE, 2'd3, 8'hB8, 1'b0, 8'h00, 4'h0);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h1);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h77, 4'h2);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h4);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'hFF, 4'h8);
		// Disabled tick blanks the pins and holds the scan position.
		cfg_row(REG_DISPLAY_ENABLE, 1'b0);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b1, 8'h00, 4'h0);
		cfg_row(REG_DISPLAY_ENABLE, 1'b1);
		cfg_row(REG_SEGMENT_ACTIVE_LOW, 1'b1);
		cfg_row(REG_DIGIT_ACTIVE_LOW, 1'b1);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b0, 8'h00, 4'h0);
		item_row(CMD_TICK, 2'd0, 8'h00, 1'b0, 8'h00, 4'h0);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.addr, row.wval);
			end else begin
				note = '{typed: row.typed, seg: row.seg, dig: row.dig};
				send_item(row.cmd, row.idx, row.code, note);
			end
		end

		// Random phases, one per combination of the three settings.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			phase_cfg = 3'(p);
			write_reg(REG_DISPLAY_ENABLE, phase_cfg[0] | (p == 1));
			write_reg(REG_SEGMENT_ACTIVE_LOW, phase_cfg[1]);
			write_reg(REG_DIGIT_ACTIVE_LOW, phase_cfg[2]);
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_SPARE, 1'($urandom));
			src_burst = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			// Back up the output while the input keeps pushing.
			if (p == 1) begin
				src_burst = 1'b1;
				sink_steady = 1'b0;
				long_hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random();
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_multiplexed_seven_segment_driver_unit passed");
		else
			$display("tb_multiplexed_seven_segment_driver_unit failed");
		$finish;
	end

endmodule
